[rtl/assert_macros.svh]
// Assertion macros shared by the pixel engine modules.
// No dependencies; ASSERT_OFF removes all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst, a, c, msg)
`define ASSERT_NXT(lbl, clk, rst, a, c, msg)
`endif
`endif

[rtl/apwb_pkg.sv]
// Types, constants and helpers for the ARGB pixel write/blend engine.
// No dependencies.
package apwb_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLIP  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEPTH  = 3'd2;
  localparam logic [2:0] REG_ALPHA  = 3'd3;
  localparam logic [2:0] REG_CLIP_L = 3'd4;
  localparam logic [2:0] REG_CLIP_T = 3'd5;
  localparam logic [2:0] REG_CLIP_R = 3'd6;
  localparam logic [2:0] REG_CLIP_B = 3'd7;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [31:0]        pixel_color;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        out_of_range;
    logic [1:0]  modified_level;
    logic        clean_flag;
    logic        no_colorkey_flag;
  } rsp_t;

  typedef struct packed {
    logic [8:0]         image_width;
    logic [8:0]         image_height;
    logic               depth_mode;
    logic [7:0]         draw_alpha;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic signed [15:0] clip_right;
    logic signed [15:0] clip_bottom;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_SCALE, ST_MIX, ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_we;
    logic load;
    logic rd_issue;
    logic scale;
    logic mix;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic raw;
  } sts_t;

  // exact a*b/255 for a,b <= 255: p/255 = (p + (p>>8) + 1) >> 8
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction
endpackage

[rtl/apwb_ctrl.sv]
// Controller of the pixel engine: clear sweep, then one item at a time.
// Depends on apwb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module apwb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  apwb_pkg::sts_t sts,
  output apwb_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import apwb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.rd_issue = 1'b1;
        state_next = (sts.is_write && !sts.raw) ? ST_SCALE : ST_DONE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_NXT(a_done_one, clk, rst, done, !done, "done held two cycles")
  `ASSERT_NXT(a_load_fetch, clk, rst, cmd.load, state == ST_FETCH, "load not followed by fetch")
  `ASSERT_IMP(a_busy_clear, clk, rst, state == ST_CLEAR, busy, "idle during clear")
endmodule

[rtl/apwb_datapath.sv]
// Datapath: config registers, frame store, bounds, blend and flags.
// Depends on apwb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module apwb_datapath (
  input  logic           clk,
  input  logic           rst,
  input  apwb_pkg::cmd_t cmd,
  output apwb_pkg::sts_t sts,
  input  apwb_pkg::req_t req,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output apwb_pkg::rsp_t rsp
);
  import apwb_pkg::*;

  cfg_t cfg;
  req_t r;
  logic [31:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic [31:0] rdata;
  logic [7:0] f;
  logic [31:0] mixed;
  logic [1:0] modified;
  logic clean, ckfree;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= 9'd256;
      cfg.image_height <= 9'd256;
      cfg.depth_mode <= 1'b1;
      cfg.draw_alpha <= 8'd255;
      cfg.clip_left <= 16'sd0;
      cfg.clip_top <= 16'sd0;
      cfg.clip_right <= 16'sd255;
      cfg.clip_bottom <= 16'sd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg.image_width <= cfg_data[8:0];
        REG_HEIGHT: cfg.image_height <= cfg_data[8:0];
        REG_DEPTH:  cfg.depth_mode <= cfg_data[0];
        REG_ALPHA:  cfg.draw_alpha <= cfg_data[7:0];
        REG_CLIP_L: cfg.clip_left <= cfg_data;
        REG_CLIP_T: cfg.clip_top <= cfg_data;
        REG_CLIP_R: cfg.clip_right <= cfg_data;
        REG_CLIP_B: cfg.clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
  end

  // bounds and address of the latched item
  logic in_img, in_clip, do_wr, bit_mode;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [AW-1:0] addr;
  logic [4:0] bidx;
  always_comb begin
    in_img = !r.pixel_x[15] && !r.pixel_y[15]
      && ({1'b0, r.pixel_x} < {8'd0, cfg.image_width})
      && ({1'b0, r.pixel_x} < 17'(MAX_WIDTH))
      && ({1'b0, r.pixel_y} < {8'd0, cfg.image_height})
      && ({1'b0, r.pixel_y} < 17'(MAX_HEIGHT));
    in_clip = (r.pixel_x >= cfg.clip_left) && (r.pixel_x <= cfg.clip_right)
      && (r.pixel_y >= cfg.clip_top) && (r.pixel_y <= cfg.clip_bottom);
    do_wr = in_img && ((r.opcode == OP_WRITE) || ((r.opcode == OP_CLIP) && in_clip));
    bit_mode = !cfg.depth_mode;
    px = r.pixel_x[XW-1:0];
    py = r.pixel_y[YW-1:0];
    addr = bit_mode ? {py, 5'd0, px[XW-1:5]} : {py, px};
    bidx = {px[4:3], ~px[2:0]};
  end

  assign sts.is_write = do_wr;
  assign sts.raw = bit_mode || (cfg.draw_alpha == 8'hff && r.pixel_color[31:24] == 8'hff);
  assign sts.clr_last = &clr_addr;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_we) clr_addr <= clr_addr + 1'b1;
  end

  // blend stages
  always_ff @(posedge clk) begin
    if (cmd.scale) f <= div255(16'(r.pixel_color[31:24] * cfg.draw_alpha));
    if (cmd.mix) begin
      mixed[31:24] <= f;
      for (int i = 0; i < 3; i++) begin
        mixed[i*8 +: 8] <= 8'((16'(r.pixel_color[i*8 +: 8] * f)
          + 16'(rdata[i*8 +: 8] * (8'd255 - f))) >> 8);
      end
    end
  end

  logic [31:0] wval;
  always_comb begin
    if (bit_mode) begin
      wval = rdata;
      wval[bidx] = (r.pixel_color != 32'd0);
    end else if (sts.raw) wval = r.pixel_color;
    else wval = mixed;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) mem[clr_addr] <= 32'd0;
    else if (cmd.commit && do_wr) mem[addr] <= wval;
    if (cmd.rd_issue) rdata <= mem[addr];
  end

  logic [1:0] mod_next;
  logic clean_next, ck_next;
  always_comb begin
    mod_next = modified;
    clean_next = clean;
    ck_next = ckfree;
    if (do_wr) begin
      if (r.pixel_color != 32'd0) begin
        mod_next = 2'd2;
        clean_next = 1'b0;
      end else begin
        mod_next = 2'd1;
        ck_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modified <= 2'd0;
      clean <= 1'b1;
      ckfree <= 1'b1;
    end else if (cmd.commit) begin
      modified <= mod_next;
      clean <= clean_next;
      ckfree <= ck_next;
    end
  end

  always_comb begin
    rsp.read_value = '0;
    rsp.out_of_range = 1'b0;
    if (r.opcode == OP_READ) begin
      if (!in_img) rsp.out_of_range = 1'b1;
      else if (bit_mode) rsp.read_value = {31'd0, rdata[bidx]};
      else rsp.read_value = rdata;
    end
    rsp.modified_level = mod_next;
    rsp.clean_flag = clean_next;
    rsp.no_colorkey_flag = ck_next;
  end

  `ASSERT_NXT(a_mod_keep, clk, rst, modified != 2'd0, modified != 2'd0, "modified fell back")
  `ASSERT_NXT(a_clean_stay, clk, rst, !clean, !clean, "clean flag rose")
  `ASSERT_NXT(a_ck_stay, clk, rst, !ckfree, !ckfree, "colorkey flag rose")
endmodule

[rtl/argb_pixel_write_blend.sv]
// Top level of the ARGB pixel write/blend engine.
// Depends on apwb_pkg, apwb_ctrl and apwb_datapath.
//
//  channel  | handshake            | payload
//  request  | start / busy         | req (opcode, pixel_x, pixel_y, pixel_color)
//  result   | result_valid strobe  | rsp (read_value, flags)
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Reads and raw writes step through load, store read and commit; blended
// writes add the alpha scale and channel mix multiplier steps between them.
// The store's single port sets the read-modify-write sequence.
// After reset a clearing pass zeroes the 65536 words with busy high.
// Results show for one cycle; the receiver cannot stall.
module argb_pixel_write_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  apwb_pkg::req_t  req,
  output logic            result_valid,
  output apwb_pkg::rsp_t  rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import apwb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  apwb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .done(result_valid)
  );

  apwb_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .req(req),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .rsp(rsp)
  );
endmodule
